>>> rtl/eida_pkg.sv
// ----------------------------------------------------------------------------
// Entity id allocator package
// Shared widths, operation and status codes, and the structs that pass
// between the control logic and the two memories.
// ----------------------------------------------------------------------------
package eida_pkg;

   localparam int MAX_ENTITIES = 256;
   localparam int ENTITY_W     = $clog2(MAX_ENTITIES);
   localparam int COUNT_W      = ENTITY_W + 1;
   localparam int COMP_BITS    = 32;
   localparam int COMP_W       = 5;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_ENTITIES);

   // Operation codes; codes above OP_QUERY behave as a query.
   localparam logic [2:0] OP_CREATE     = 3'd0;
   localparam logic [2:0] OP_REMOVE     = 3'd1;
   localparam logic [2:0] OP_ADD_COMP   = 3'd2;
   localparam logic [2:0] OP_CLEAR_COMP = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALIVE = 2'd2;

   typedef logic [ENTITY_W-1:0]  entity_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [COMP_BITS-1:0] mask_type;

   // One word of the entity memory.
   typedef struct packed {
      logic     alive;
      mask_type mask;
   } entry_type;

   // Write port of the entity memory.
   typedef struct packed {
      logic       en;
      entity_type addr;
      entry_type  data;
   } entry_wr_type;

   // Control of the free stack.
   typedef struct packed {
      logic       rd_en;
      logic       pop;
      logic       push;
      entity_type push_id;
   } stack_ctrl_type;

endpackage

>>> rtl/entity_id_allocator_with_masks_top.sv
// ----------------------------------------------------------------------------
// Entity id allocator with component masks
// Hands out entity ids from a LIFO free list or a fresh counter and keeps a
// component mask and an alive bit per entity.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_stall   operation, entity, component
//   rsp_     out        rsp_valid/rsp_stall   entity_id, status, mask, alive
//
// Every transaction has an accept cycle and an execute state: the accept cycle
// issues the reads of the entity memory and the free stack, and the execute
// state uses the registered read data, writes back and loads the result
// register. A new transaction can be accepted in the cycle after the execute
// state commits, so writes always land before the next read and no forwarding is needed.
// Reset is synchronous and active high. The entity memory has a valid bit
// per entry, so the block is ready in the first cycle after reset.
// While a result waits under rsp_stall, one more request is accepted and
// held in the execute state until the result register is free.
//
module entity_id_allocator_with_masks_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_operation,
   input  logic [7:0]                 req_entity,
   input  logic [4:0]                 req_component,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_entity_id,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_mask,
   output logic                       rsp_alive
);
   import eida_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // Control state.
   logic       state_ff;
   logic       state_in;
   count_type  live_count_ff;
   count_type  live_count_in;
   count_type  next_fresh_ff;
   count_type  next_fresh_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Captured request.
   logic [2:0]        op_ff;
   entity_type        ent_ff;
   logic [COMP_W-1:0] comp_ff;

   // Result register.
   entity_type rsp_id_ff;
   entity_type rsp_id_in;
   logic [1:0] rsp_status_ff;
   logic [1:0] rsp_status_in;
   mask_type   rsp_mask_ff;
   mask_type   rsp_mask_in;
   logic       rsp_alive_ff;
   logic       rsp_alive_in;

   logic           req_take;
   logic           exec_go;
   entry_type      rd_entry;
   entry_wr_type   entry_wr;
   stack_ctrl_type stack_ctrl;
   entity_type     stack_top;
   logic           stack_empty;
   logic           full;
   entity_type     new_id;
   mask_type       comp_bit;

   // The read data of both memories is valid in the cycle after the accept.
   eida_entity_mem u_entity_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (req_entity),
      .rd_data (rd_entry),
      .wr      (entry_wr)
   );

   eida_free_stack u_free_stack (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (stack_ctrl),
      .top_id (stack_top),
      .empty  (stack_empty)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // The execute cycle commits only when the result register can be loaded.
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign full     = (live_count_ff >= COUNT_LIMIT);
   assign new_id   = stack_empty ? next_fresh_ff[ENTITY_W-1:0] : stack_top;
   assign comp_bit = mask_type'(1) << comp_ff;

   always_comb begin
      entry_wr            = '0;
      entry_wr.addr       = ent_ff;
      entry_wr.data       = rd_entry;
      stack_ctrl          = '0;
      stack_ctrl.rd_en    = req_take;
      stack_ctrl.push_id  = ent_ff;
      live_count_in       = live_count_ff;
      next_fresh_in       = next_fresh_ff;
      rsp_id_in           = ent_ff;
      rsp_status_in       = STATUS_OK;
      rsp_mask_in         = rd_entry.mask;
      rsp_alive_in        = rd_entry.alive;

      unique case (op_ff)
         OP_CREATE: begin
            if (full) begin
               // Nothing is allocated and the result carries only the status.
               rsp_id_in     = '0;
               rsp_status_in = STATUS_FULL;
               rsp_mask_in   = '0;
               rsp_alive_in  = 1'b0;
            end else begin
               entry_wr.en         = exec_go;
               entry_wr.addr       = new_id;
               entry_wr.data.alive = 1'b1;
               entry_wr.data.mask  = '0;
               stack_ctrl.pop      = exec_go && !stack_empty;
               if (exec_go && stack_empty) begin
                  next_fresh_in = next_fresh_ff + COUNT_W'(1);
               end
               if (exec_go) begin
                  live_count_in = live_count_ff + COUNT_W'(1);
               end
               rsp_id_in    = new_id;
               rsp_mask_in  = '0;
               rsp_alive_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            // The mask is cleared whether or not the entity was live.
            entry_wr.en   = exec_go;
            entry_wr.data = '0;
            if (rd_entry.alive) begin
               stack_ctrl.push = exec_go;
               if (exec_go && (live_count_ff != '0)) begin
                  live_count_in = live_count_ff - COUNT_W'(1);
               end
            end else begin
               rsp_status_in = STATUS_NOT_ALIVE;
            end
            rsp_mask_in  = '0;
            rsp_alive_in = 1'b0;
         end
         OP_ADD_COMP: begin
            entry_wr.en        = exec_go;
            entry_wr.data.mask = rd_entry.mask | comp_bit;
            rsp_mask_in        = rd_entry.mask | comp_bit;
         end
         OP_CLEAR_COMP: begin
            entry_wr.en        = exec_go;
            entry_wr.data.mask = rd_entry.mask & ~comp_bit;
            rsp_mask_in        = rd_entry.mask & ~comp_bit;
         end
         default: begin
            // A query, and every unused code, just reports the entry.
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         state_in = ST_EXEC;
      end else if (exec_go) begin
         state_in = ST_IDLE;
      end
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         live_count_ff <= '0;
         next_fresh_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         live_count_ff <= live_count_in;
         next_fresh_ff <= next_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_operation;
         ent_ff  <= req_entity;
         comp_ff <= req_component;
      end
      if (exec_go) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
         rsp_mask_ff   <= rsp_mask_in;
         rsp_alive_ff  <= rsp_alive_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_entity_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_mask      = rsp_mask_ff;
   assign rsp_alive     = rsp_alive_ff;

endmodule

>>> rtl/eida_entity_mem.sv
// ----------------------------------------------------------------------------
// Entity memory
// Alive bit and component mask of every entity in one synchronous memory
// with registered read data. Per-entry valid bits make unwritten entries
// read as dead with an empty mask, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module eida_entity_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  eida_pkg::entity_type   rd_addr,
   output eida_pkg::entry_type    rd_data,
   input  eida_pkg::entry_wr_type wr
);
   import eida_pkg::*;

   entry_type               entry_mem_ff [MAX_ENTITIES];
   logic [MAX_ENTITIES-1:0] written_ff;
   entry_type               rd_word_ff;
   logic                    rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_word_ff    <= entry_mem_ff[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_written_ff ? rd_word_ff : '0;

endmodule

>>> rtl/eida_free_stack.sv
// ----------------------------------------------------------------------------
// Free id stack
// LIFO of freed entity ids in a synchronous memory. The top entry is read
// into a register when ctrl.rd_en is set, ahead of the pop that consumes it.
// ----------------------------------------------------------------------------
module eida_free_stack (
   input  logic                     clock,
   input  logic                     reset,
   input  eida_pkg::stack_ctrl_type ctrl,
   output eida_pkg::entity_type     top_id,
   output logic                     empty
);
   import eida_pkg::*;

   entity_type stack_mem_ff [MAX_ENTITIES];
   count_type  count_ff;
   count_type  count_in;
   entity_type top_ff;
   entity_type top_addr;

   assign top_addr = count_ff[ENTITY_W-1:0] - ENTITY_W'(1);

   always_ff @(posedge clock) begin
      if (ctrl.push && (count_ff < COUNT_LIMIT)) begin
         stack_mem_ff[count_ff[ENTITY_W-1:0]] <= ctrl.push_id;
      end
      if (ctrl.rd_en) begin
         top_ff <= stack_mem_ff[top_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.pop && (count_ff != '0)) begin
         count_in = count_ff - COUNT_W'(1);
      end else if (ctrl.push && (count_ff < COUNT_LIMIT)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_id = top_ff;
   assign empty  = (count_ff == '0);

endmodule

>>> rtl/eida_checker.sv
// ----------------------------------------------------------------------------
// Entity id allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module eida_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_entity_id,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_mask,
   input logic        rsp_alive
);
   import eida_pkg::*;

   // No result may be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Each accepted transaction blocks the next cycle's request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted in back-to-back cycles");

   // A refused create carries no id, mask or alive bit.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
      ((rsp_entity_id == '0) && (rsp_mask == '0) && !rsp_alive))
      else $error("full result with payload");

   // A not-alive result carries an empty mask and a cleared alive bit.
   a_not_alive_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOT_ALIVE)) |->
      ((rsp_mask == '0) && !rsp_alive))
      else $error("not-alive result with live entity");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_entity_id) && $stable(rsp_mask)))
      else $error("stalled result changed");

endmodule

bind entity_id_allocator_with_masks_top eida_checker u_eida_checker (.*);
